// File: hw/rtl/rdh_pkg.sv
// Shared types, constants and helper functions of the root density histogram.
package rdh_pkg;

    // Image limits and the count store that follows from them.
    localparam int MAX_X_RES = 512;
    localparam int MAX_Y_RES = 512;
    localparam int DEPTH     = MAX_X_RES * MAX_Y_RES;
    localparam int DEPTH_W   = $clog2(DEPTH);

    // Field widths.
    localparam int Q_W       = 32;
    localparam int DIFF_W    = Q_W + 1;
    localparam int RES_W     = 10;
    localparam int INDEX_W   = 18;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RES   = 3'd5;

    // Command codes of an input request.
    localparam logic CMD_PLOT = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Numeric constants.
    localparam logic signed [Q_W-1:0] HALF_Q16     = 32'sd32768;
    localparam logic signed [Q_W-1:0] NEG_HALF_Q16 = -32'sd32768;
    localparam logic [CNT_W-1:0]      CNT_MAX      = '1;
    localparam logic [Q_W-1:0]        SCALE_RESET  = 32'd65536;
    localparam logic [RES_W-1:0]      RES_RESET    = 10'd512;

    // Operation that a request carries into the count store.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PLOT,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] index;
    } item_t;

    typedef struct packed {
        logic [Q_W-1:0]   x_min;
        logic [Q_W-1:0]   x_scale;
        logic [Q_W-1:0]   y_min;
        logic [Q_W-1:0]   y_scale;
        logic [RES_W-1:0] x_res;
        logic [RES_W-1:0] y_res;
    } cfg_t;

    // A written resolution above the image limit saturates to that limit.
    function automatic logic [RES_W-1:0] clamp_res(input logic [RES_W-1:0] v,
                                                   input int maxv);
        logic [RES_W-1:0] r;
        r = v;
        if (int'(v) > maxv) begin
            r = RES_W'(maxv);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/rdh_map.sv
// Coordinate mapping pipeline: root to pixel index, or read index pass-through.
module rdh_map (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rdh_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_command,
    input  logic signed [rdh_pkg::Q_W-1:0] in_root_re,
    input  logic signed [rdh_pkg::Q_W-1:0] in_root_im,
    input  logic [rdh_pkg::INDEX_W-1:0]   in_read_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rdh_pkg::item_t                out_item
);

    localparam int QW = rdh_pkg::Q_W;
    localparam int DW = rdh_pkg::DIFF_W;
    localparam int RW = rdh_pkg::RES_W;
    localparam int IW = rdh_pkg::INDEX_W;
    localparam logic [IW:0] DEPTH_CMP = (IW + 1)'(rdh_pkg::DEPTH);

    // Stage A: differences to the region edges and the real-axis skip test.
    logic          a_valid_reg, a_cmd_reg, a_skip_reg;
    logic [DW-1:0] a_dx_reg, a_dy_reg;
    logic [IW-1:0] a_ridx_reg;
    // Stage B: sign and magnitude.
    logic          b_valid_reg, b_cmd_reg, b_skip_reg, b_nx_reg, b_ny_reg;
    logic [QW-1:0] b_mx_reg, b_my_reg;
    logic [IW-1:0] b_ridx_reg;
    // Stage C: scaled magnitudes.
    logic          c_valid_reg, c_cmd_reg, c_skip_reg, c_nx_reg, c_ny_reg;
    logic [QW-1:0] c_qx_reg, c_qy_reg;
    logic [IW-1:0] c_ridx_reg;
    // Stage D: bounds test and pixel coordinates.
    logic           d_valid_reg;
    rdh_pkg::op_t   d_op_reg;
    logic [RW-1:0]  d_x_reg, d_y_reg;
    logic [IW-1:0]  d_pass_reg;
    // Stage E: linear pixel index.
    logic           e_valid_reg;
    rdh_pkg::item_t e_item_reg;

    logic adv_a, adv_b, adv_c, adv_d, adv_e;

    assign adv_e    = !e_valid_reg || out_ready;
    assign adv_d    = !d_valid_reg || adv_e;
    assign adv_c    = !c_valid_reg || adv_d;
    assign adv_b    = !b_valid_reg || adv_c;
    assign adv_a    = !a_valid_reg || adv_b;
    assign in_ready = adv_a;

    // Stage A.
    logic [DW-1:0] a_dx_next, a_dy_next;
    logic          a_skip_next;

    always_comb begin
        a_dx_next   = {in_root_re[QW-1], in_root_re} - {cfg.x_min[QW-1], cfg.x_min};
        a_dy_next   = {in_root_im[QW-1], in_root_im} - {cfg.y_min[QW-1], cfg.y_min};
        a_skip_next = (in_root_im == '0) &&
                      ((in_root_re < rdh_pkg::NEG_HALF_Q16) ||
                       (in_root_re > rdh_pkg::HALF_Q16));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv_a) begin
            a_valid_reg <= in_valid;
        end
        if (adv_a) begin
            a_cmd_reg  <= in_command;
            a_skip_reg <= a_skip_next;
            a_dx_reg   <= a_dx_next;
            a_dy_reg   <= a_dy_next;
            a_ridx_reg <= in_read_index;
        end
    end

    // Stage B. The difference never reaches 2^32 in magnitude, so 32 bits hold it.
    logic [DW-1:0] b_negx, b_negy;

    assign b_negx = -a_dx_reg;
    assign b_negy = -a_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv_b) begin
            b_valid_reg <= a_valid_reg;
        end
        if (adv_b) begin
            b_cmd_reg  <= a_cmd_reg;
            b_skip_reg <= a_skip_reg;
            b_nx_reg   <= a_dx_reg[DW-1];
            b_ny_reg   <= a_dy_reg[DW-1];
            b_mx_reg   <= a_dx_reg[DW-1] ? b_negx[QW-1:0] : a_dx_reg[QW-1:0];
            b_my_reg   <= a_dy_reg[DW-1] ? b_negy[QW-1:0] : a_dy_reg[QW-1:0];
            b_ridx_reg <= a_ridx_reg;
        end
    end

    // Stage C: one 32 by 32 multiplier per axis, keeping the integer part.
    logic [2*QW-1:0] prod_x, prod_y;

    assign prod_x = b_mx_reg * cfg.x_scale;
    assign prod_y = b_my_reg * cfg.y_scale;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv_c) begin
            c_valid_reg <= b_valid_reg;
        end
        if (adv_c) begin
            c_cmd_reg  <= b_cmd_reg;
            c_skip_reg <= b_skip_reg;
            c_nx_reg   <= b_nx_reg;
            c_ny_reg   <= b_ny_reg;
            c_qx_reg   <= prod_x[2*QW-1:QW];
            c_qy_reg   <= prod_y[2*QW-1:QW];
            c_ridx_reg <= b_ridx_reg;
        end
    end

    // Stage D. A negative scaled column is inside only when it truncated to zero.
    // The row is y_res minus the scaled value, so only a positive value not
    // above y_res lands inside.
    logic         x_ok, y_ok, rd_hit;
    rdh_pkg::op_t d_op_next;

    always_comb begin
        x_ok   = (!c_nx_reg || (c_qx_reg == '0)) && (c_qx_reg < QW'(cfg.x_res));
        y_ok   = !c_ny_reg && (c_qy_reg != '0) && (c_qy_reg <= QW'(cfg.y_res));
        rd_hit = {1'b0, c_ridx_reg} < DEPTH_CMP;
        d_op_next = rdh_pkg::OP_NONE;
        if (c_cmd_reg == rdh_pkg::CMD_READ) begin
            if (rd_hit) begin
                d_op_next = rdh_pkg::OP_READ;
            end
        end else if (!c_skip_reg && x_ok && y_ok) begin
            d_op_next = rdh_pkg::OP_PLOT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv_d) begin
            d_valid_reg <= c_valid_reg;
        end
        if (adv_d) begin
            d_op_reg   <= d_op_next;
            d_x_reg    <= c_qx_reg[RW-1:0];
            d_y_reg    <= cfg.y_res - c_qy_reg[RW-1:0];
            d_pass_reg <= (c_cmd_reg == rdh_pkg::CMD_READ) ? c_ridx_reg : '0;
        end
    end

    // Stage E.
    logic [2*RW-1:0] row_base, pix_sum;

    assign row_base = d_y_reg * cfg.x_res;
    assign pix_sum  = row_base + (2*RW)'(d_x_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (adv_e) begin
            e_valid_reg <= d_valid_reg;
        end
        if (adv_e) begin
            e_item_reg.op    <= d_op_reg;
            e_item_reg.index <= (d_op_reg == rdh_pkg::OP_PLOT) ? pix_sum[IW-1:0] : d_pass_reg;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_item  = e_item_reg;

endmodule

// File: hw/rtl/rdh_store.sv
// Count store: clearing pass, read-modify-write with forwarding, running maximum.
module rdh_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rdh_pkg::item_t                in_item,
    output logic                          busy,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_plotted,
    output logic [rdh_pkg::INDEX_W-1:0]   m_pixel_index,
    output logic [rdh_pkg::CNT_W-1:0]     m_pixel_count,
    output logic [rdh_pkg::CNT_W-1:0]     m_peak_count
);

    localparam int AW = rdh_pkg::DEPTH_W;
    localparam int CW = rdh_pkg::CNT_W;
    localparam int IW = rdh_pkg::INDEX_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(rdh_pkg::DEPTH - 1);

    logic [CW-1:0] mem_array [0:rdh_pkg::DEPTH-1];
    logic [CW-1:0] mem_q_reg;

    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic           u_valid_reg;
    rdh_pkg::item_t u_item_reg;

    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [CW-1:0] fwd_data_reg;

    logic [CW-1:0] max_reg, max_next;

    logic          o_valid_reg, o_plotted_reg;
    logic [IW-1:0] o_index_reg;
    logic [CW-1:0] o_count_reg, o_max_reg;

    logic          adv_o, adv_u, u_leave, wr_plot, wr_en;
    logic [AW-1:0] rd_addr, u_addr, wr_addr;
    logic [CW-1:0] cur, inc, wr_data, count_sel;

    assign adv_o    = !o_valid_reg || m_ready;
    assign adv_u    = !u_valid_reg || adv_o;
    assign in_ready = adv_u;
    assign busy     = clr_busy_reg;

    assign rd_addr = in_item.index[AW-1:0];
    assign u_addr  = u_item_reg.index[AW-1:0];
    assign u_leave = u_valid_reg && adv_o;
    assign wr_plot = u_leave && (u_item_reg.op == rdh_pkg::OP_PLOT);

    // The write of the request just ahead lands on the same edge as this read.
    always_comb begin
        cur = mem_q_reg;
        if (fwd_valid_reg && (fwd_addr_reg == u_addr)) begin
            cur = fwd_data_reg;
        end
        inc = (cur == rdh_pkg::CNT_MAX) ? cur : cur + 1'b1;
        max_next = (wr_plot && (inc > max_reg)) ? inc : max_reg;
        case (u_item_reg.op)
            rdh_pkg::OP_PLOT: count_sel = inc;
            rdh_pkg::OP_READ: count_sel = cur;
            default:          count_sel = '0;
        endcase
    end

    assign wr_en   = clr_busy_reg || wr_plot;
    assign wr_addr = clr_busy_reg ? clr_addr_reg : u_addr;
    assign wr_data = clr_busy_reg ? '0 : inc;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_u) begin
            mem_q_reg <= mem_array[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            max_reg       <= '0;
            o_valid_reg   <= 1'b0;
        end else begin
            if (adv_u) begin
                u_valid_reg <= in_valid;
            end
            if (wr_plot) begin
                fwd_valid_reg <= 1'b1;
            end
            max_reg <= max_next;
            if (adv_o) begin
                o_valid_reg <= u_valid_reg;
            end
        end
        if (adv_u) begin
            u_item_reg <= in_item;
        end
        if (wr_plot) begin
            fwd_addr_reg <= u_addr;
            fwd_data_reg <= inc;
        end
        if (u_leave) begin
            o_plotted_reg <= (u_item_reg.op == rdh_pkg::OP_PLOT);
            o_index_reg   <= u_item_reg.index;
            o_count_reg   <= count_sel;
            o_max_reg     <= max_next;
        end
    end

    assign m_valid       = o_valid_reg;
    assign m_plotted     = o_plotted_reg;
    assign m_pixel_index = o_index_reg;
    assign m_pixel_count = o_count_reg;
    assign m_peak_count  = o_max_reg;

endmodule

// File: hw/rtl/root_density_histogram.sv
// Top level of the root density histogram: configuration registers and the two pipeline parts.
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      s_command, s_root_re, s_root_im, s_read_index
//  m_        out        m_valid / m_ready      m_plotted, m_pixel_index, m_pixel_count, m_peak_count
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request is accepted per clock cycle when not clearing and results are taken, and
// each request gives exactly one result through the coordinate mapping stages, the count
// store read and the output register. The read-modify-write of the count store, with
// separate read and write ports and closed by forwarding the previous write, sets the
// rate of one request a cycle. After reset a clearing pass writes zero to every count,
// one entry per cycle, over MAX_X_RES * MAX_Y_RES entries (262144 at the default size);
// s_ready stays low meanwhile, while configuration writes are taken at once. Every stage
// holds its own valid bit, so a stalled result only stops the stages behind it once full.
module root_density_histogram (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input requests.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic signed [rdh_pkg::Q_W-1:0]     s_root_re,
    input  logic signed [rdh_pkg::Q_W-1:0]     s_root_im,
    input  logic [rdh_pkg::INDEX_W-1:0]        s_read_index,
    // Results.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_plotted,
    output logic [rdh_pkg::INDEX_W-1:0]        m_pixel_index,
    output logic [rdh_pkg::CNT_W-1:0]          m_pixel_count,
    output logic [rdh_pkg::CNT_W-1:0]          m_peak_count,
    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rdh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rdh_pkg::Q_W-1:0]            cfg_data
);

    localparam int RW = rdh_pkg::RES_W;

    rdh_pkg::cfg_t  cfg_reg;
    rdh_pkg::item_t map_item;
    logic           map_in_ready, map_out_valid, store_in_ready, store_busy;

    // Configuration writes are always taken; an index beyond the list is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_min   <= '0;
            cfg_reg.x_scale <= rdh_pkg::SCALE_RESET;
            cfg_reg.y_min   <= '0;
            cfg_reg.y_scale <= rdh_pkg::SCALE_RESET;
            cfg_reg.x_res   <= rdh_pkg::clamp_res(rdh_pkg::RES_RESET, rdh_pkg::MAX_X_RES);
            cfg_reg.y_res   <= rdh_pkg::clamp_res(rdh_pkg::RES_RESET, rdh_pkg::MAX_Y_RES);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rdh_pkg::CFG_X_MIN:   cfg_reg.x_min   <= cfg_data;
                rdh_pkg::CFG_X_SCALE: cfg_reg.x_scale <= cfg_data;
                rdh_pkg::CFG_Y_MIN:   cfg_reg.y_min   <= cfg_data;
                rdh_pkg::CFG_Y_SCALE: cfg_reg.y_scale <= cfg_data;
                rdh_pkg::CFG_X_RES:
                    cfg_reg.x_res <= rdh_pkg::clamp_res(cfg_data[RW-1:0], rdh_pkg::MAX_X_RES);
                rdh_pkg::CFG_Y_RES:
                    cfg_reg.y_res <= rdh_pkg::clamp_res(cfg_data[RW-1:0], rdh_pkg::MAX_Y_RES);
                default: ;
            endcase
        end
    end

    // No request enters while the count store is still being cleared.
    assign s_ready = map_in_ready && !store_busy;

    rdh_map u_map (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (s_valid && !store_busy),
        .in_ready      (map_in_ready),
        .in_command    (s_command),
        .in_root_re    (s_root_re),
        .in_root_im    (s_root_im),
        .in_read_index (s_read_index),
        .out_valid     (map_out_valid),
        .out_ready     (store_in_ready),
        .out_item      (map_item)
    );

    rdh_store u_store (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (map_out_valid),
        .in_ready      (store_in_ready),
        .in_item       (map_item),
        .busy          (store_busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_plotted     (m_plotted),
        .m_pixel_index (m_pixel_index),
        .m_pixel_count (m_pixel_count),
        .m_peak_count  (m_peak_count)
    );

endmodule

// File: hw/rtl/rdh_checker.sv
// Port-level checks of the root density histogram and their binding to the top level.
module rdh_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_plotted,
    input logic [rdh_pkg::CNT_W-1:0]     m_pixel_count,
    input logic [rdh_pkg::CNT_W-1:0]     m_peak_count
);

    logic [rdh_pkg::CNT_W-1:0] last_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_max_reg <= '0;
        end else if (m_valid && m_ready) begin
            last_max_reg <= m_peak_count;
        end
    end

    // Reset starts the clearing pass, during which no request is taken.
    a_clear_after_reset: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("request taken straight after reset");

    // A plotted count is at least one and never above the running maximum.
    a_plot_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_plotted |-> (m_pixel_count != '0) && (m_pixel_count <= m_peak_count))
        else $error("plotted count out of bounds");

    // The running maximum never falls from one result to the next.
    a_max_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_peak_count >= last_max_reg)
        else $error("running maximum decreased");

    // A stalled result holds its counts.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_count) && $stable(m_peak_count))
        else $error("stalled result changed");

endmodule

bind root_density_histogram rdh_checker u_rdh_checker (.*);

// File: dv/tb_root_density_histogram.sv
// Self-checking testbench of the root density histogram: request driver, result monitor, bin predictor.
`timescale 1ns / 100ps

module tb_root_density_histogram;
    import rdh_pkg::*;

    // Register indexes that the block has no register behind; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // One input request as the driver presents it.
    typedef struct {
        logic                      command;
        logic signed [Q_W-1:0]     re;
        logic signed [Q_W-1:0]     im;
        logic [INDEX_W-1:0]        read_index;
    } root_req_t;

    // One result of the histogram, as predicted and as observed.
    typedef struct {
        logic                      plotted;
        logic [INDEX_W-1:0]        index;
        logic [CNT_W-1:0]          count;
        logic [CNT_W-1:0]          peak;
    } bin_result_t;

    // All inputs of the block carry known values from time zero onwards.
    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_command = CMD_PLOT;
    logic signed [Q_W-1:0]         s_root_re = '0;
    logic signed [Q_W-1:0]         s_root_im = '0;
    logic [INDEX_W-1:0]            s_read_index = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_plotted;
    logic [INDEX_W-1:0]            m_pixel_index;
    logic [CNT_W-1:0]              m_pixel_count;
    logic [CNT_W-1:0]              m_peak_count;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [Q_W-1:0]                cfg_data = '0;

    // Our own copy of the histogram: the count store, the running peak and the registers.
    bit [CNT_W-1:0]                hist_counts [DEPTH];
    logic [CNT_W-1:0]              hist_peak = '0;
    logic signed [Q_W-1:0]         reg_x_min = '0;
    logic [Q_W-1:0]                reg_x_scale = SCALE_RESET;
    logic signed [Q_W-1:0]         reg_y_min = '0;
    logic [Q_W-1:0]                reg_y_scale = SCALE_RESET;
    longint                        reg_x_res = MAX_X_RES;
    longint                        reg_y_res = MAX_Y_RES;

    // Requests waiting for the driver, the one on the bus, and results still to come back.
    root_req_t                     root_queue [$];
    root_req_t                     in_flight;
    bin_result_t                   bin_results_due [$];
    int                            roots_queued = 0;
    int                            roots_taken = 0;
    int                            mismatches = 0;

    // Idling percentages of the present phase.
    int                            send_idle_pct = 0;
    int                            recv_stall_pct = 0;

    root_density_histogram DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_root_re     (s_root_re),
        .s_root_im     (s_root_im),
        .s_read_index  (s_read_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_plotted     (m_plotted),
        .m_pixel_index (m_pixel_index),
        .m_pixel_count (m_pixel_count),
        .m_peak_count  (m_peak_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The block's mapping of an offset onto pixels: the magnitude of the 33 bit difference
    // times the scale, the top 32 bits of that product kept, then the sign put back. This is
    // truncation toward zero, so a tiny negative offset still lands on pixel zero.
    function automatic longint scaled_offset(input longint diff, input logic [Q_W-1:0] scale);
        longint unsigned mag;
        longint unsigned prod;
        mag = (diff < 0) ? -diff : diff;
        prod = (mag * scale) >> 32;
        return (diff < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // Works out the result of one accepted request and updates our copy of the histogram.
    function automatic bin_result_t bin_request(input root_req_t req);
        bin_result_t res;
        longint      x;
        longint      y;
        int          pix;
        res = '{plotted: 1'b0, index: '0, count: '0, peak: '0};
        if (req.command == CMD_READ) begin
            // The store is exactly as deep as the index is wide, so every index reads an entry.
            res.index = req.read_index;
            res.count = hist_counts[req.read_index];
        end else if (!(req.im == 0 && (req.re < NEG_HALF_Q16 || req.re > HALF_Q16))) begin
            // Roots on the real axis beyond half a unit either side are skipped above.
            x = scaled_offset(longint'(req.re) - longint'(reg_x_min), reg_x_scale);
            y = reg_y_res - scaled_offset(longint'(req.im) - longint'(reg_y_min), reg_y_scale);
            if (x >= 0 && x < reg_x_res && y >= 0 && y < reg_y_res) begin
                pix = int'(y * reg_x_res + x);
                if (hist_counts[pix] != CNT_MAX) begin
                    hist_counts[pix] = hist_counts[pix] + 1;
                end
                if (hist_counts[pix] > hist_peak) begin
                    hist_peak = hist_counts[pix];
                end
                res.plotted = 1'b1;
                res.index = pix[INDEX_W-1:0];
                res.count = hist_counts[pix];
            end
        end
        res.peak = hist_peak;
        return res;
    endfunction

    // Picks a coordinate around the plotted region along one axis: mostly inside, with a
    // margin on both sides so that edges and roots just outside are hit as well.
    function automatic logic [Q_W-1:0] aim_coord(input logic signed [Q_W-1:0] lo,
                                                 input longint res,
                                                 input logic [Q_W-1:0] scale);
        longint span;
        longint rnd;
        longint v;
        span = (scale == 0) ? (64'sd1 <<< 32) : ((res + 1) <<< 32) / longint'(scale);
        if (span > (64'sd1 <<< 32)) begin
            span = 64'sd1 <<< 32;
        end
        rnd = {1'b0, 31'($urandom), $urandom};
        v = longint'(lo) + rnd % (span + span / 8 + 3) - span / 16 - 1;
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
        end
        return v[Q_W-1:0];
    endfunction

    // Prints one line per mismatch, up to a cap so that a broken block cannot flood the log.
    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t: %s differs, got %h, want %h", $time, what, got, want);
        end
    endtask

    task automatic queue_plot(input logic [Q_W-1:0] re, input logic [Q_W-1:0] im);
        root_queue.push_back('{command: CMD_PLOT, re: re, im: im,
                               read_index: INDEX_W'($urandom)});
        roots_queued++;
    endtask

    task automatic queue_read(input logic [INDEX_W-1:0] idx);
        root_queue.push_back('{command: CMD_READ, re: $urandom, im: $urandom, read_index: idx});
        roots_queued++;
    endtask

    // One configuration write; our copy of the register follows once the block takes it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_X_MIN:   reg_x_min = value;
            CFG_X_SCALE: reg_x_scale = value;
            CFG_Y_MIN:   reg_y_min = value;
            CFG_Y_SCALE: reg_y_scale = value;
            // Only the low ten bits count, and anything above the image size saturates.
            CFG_X_RES:   reg_x_res = (value[RES_W-1:0] > MAX_X_RES) ? MAX_X_RES
                                                                    : value[RES_W-1:0];
            CFG_Y_RES:   reg_y_res = (value[RES_W-1:0] > MAX_Y_RES) ? MAX_Y_RES
                                                                    : value[RES_W-1:0];
            default: ;
        endcase
    endtask

    // Holds the stimulus back until every queued request has been taken and answered.
    task automatic drain_bins();
        while (roots_taken != roots_queued || bin_results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // One phase: a fresh setting of all six registers, then a stream of random requests with
    // a full pause half way through. Most requests are aimed into the plotted region; the rest
    // are reads, roots on the real axis near the skip threshold, and plain noise.
    task automatic run_phase(input logic [Q_W-1:0] x_min, input logic [Q_W-1:0] x_scale,
                             input logic [Q_W-1:0] y_min, input logic [Q_W-1:0] y_scale,
                             input logic [Q_W-1:0] x_res, input logic [Q_W-1:0] y_res,
                             input int send_pct, input int recv_pct, input int n);
        int pick;
        longint area;
        drain_bins();
        write_reg(CFG_X_MIN, x_min);
        write_reg(CFG_X_SCALE, x_scale);
        write_reg(CFG_Y_MIN, y_min);
        write_reg(CFG_Y_SCALE, y_scale);
        write_reg(CFG_X_RES, x_res);
        write_reg(CFG_Y_RES, y_res);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        area = reg_x_res * reg_y_res;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) begin
                drain_bins();
            end
            pick = $urandom_range(99);
            if (pick < 15) begin
                if (area > 0 && $urandom_range(1) == 1) begin
                    queue_read(INDEX_W'($urandom_range(0, int'(area - 1))));
                end else begin
                    queue_read(INDEX_W'($urandom));
                end
            end else if (pick < 23) begin
                queue_plot(32'(int'($urandom_range(0, 80000)) - 40000), '0);
            end else if (pick < 33) begin
                queue_plot($urandom, $urandom);
            end else begin
                queue_plot(aim_coord(reg_x_min, reg_x_res, reg_x_scale),
                           aim_coord(reg_y_min, reg_y_res, reg_y_scale));
            end
        end
    endtask

    // Driver: presents the next queued request once the bus is free, and hands each accepted
    // request to the predictor at the edge where it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                bin_results_due.push_back(bin_request(in_flight));
                roots_taken++;
            end
            if (!s_valid || s_ready) begin
                if (root_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = root_queue.pop_front();
                    s_valid <= 1'b1;
                    s_command <= in_flight.command;
                    s_root_re <= in_flight.re;
                    s_root_im <= in_flight.im;
                    s_read_index <= in_flight.read_index;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result taken is checked field by field against the oldest prediction.
    always @(posedge aclk) begin
        bin_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (bin_results_due.size() == 0) begin
                    report_mismatch("result with nothing due, index",
                                    CNT_W'(m_pixel_index), '0);
                end else begin
                    want = bin_results_due.pop_front();
                    if (m_plotted !== want.plotted) begin
                        report_mismatch("plotted", CNT_W'(m_plotted), CNT_W'(want.plotted));
                    end
                    if (m_pixel_index !== want.index) begin
                        report_mismatch("pixel_index", CNT_W'(m_pixel_index),
                                        CNT_W'(want.index));
                    end
                    if (m_pixel_count !== want.count) begin
                        report_mismatch("pixel_count", m_pixel_count, want.count);
                    end
                    if (m_peak_count !== want.peak) begin
                        report_mismatch("peak_count", m_peak_count, want.peak);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus. The block clears its store after reset; requests simply wait on s_ready
    // during that pass.
    initial begin
        int send_modes [4];
        int recv_modes [4];
        send_modes = '{0, 78, 0, 14};
        recv_modes = '{0, 0, 78, 14};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests at the reset setting: one unit per pixel, origin at zero.
        queue_plot(32'h0005_8000, 32'h0003_4000);   // column 5, row 509
        queue_plot(32'h0005_8000, 32'h0003_4000);   // same pixel, count and peak reach two
        queue_plot(32'h0000_0000, 32'h0001_0000);   // left column, bottom row
        queue_plot(32'h01FF_FFFF, 32'h0200_FFFF);   // right column, top row
        queue_plot(32'h0200_0000, 32'h0001_0000);   // one column past the right edge
        queue_plot(32'hFFFF_FFFF, 32'h0001_0000);   // tiny negative offset truncates to zero
        queue_plot(32'h0001_0000, 32'h0000_FFFF);   // just below the bottom row
        queue_plot(32'h8000_0000, 32'h7FFF_FFFF);
        queue_plot(32'h7FFF_FFFF, 32'h8000_0000);
        queue_plot(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_plot(32'h8000_0000, 32'h8000_0000);
        queue_read(18'(509 * 512 + 5));
        queue_read('0);
        queue_read('1);
        queue_read(18'd511);
        drain_bins();

        // Shift the origin so that the real axis falls inside the image, then probe both
        // sides of the half-unit threshold where roots on the axis start being skipped.
        write_reg(CFG_X_MIN, 32'hFFFF_0000);
        write_reg(CFG_Y_MIN, 32'hFFF6_0000);
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h0000_0001);
        queue_plot(32'h0000_8000, '0);               // exactly +0.5 is still plotted
        queue_plot(32'hFFFF_8000, '0);               // exactly -0.5 is still plotted
        queue_plot(32'h0000_8001, '0);
        queue_plot(32'hFFFF_7FFF, '0);
        queue_plot(32'h7FFF_FFFF, '0);
        queue_plot(32'h8000_0000, '0);
        queue_plot(32'h0000_8001, 32'h0000_0001);    // off the axis, so not skipped
        queue_read(18'(502 * 512 + 1));
        queue_read(18'(502 * 512));

        // Fixed settings, the extremes among them.
        run_phase(32'hFFFE_0000, 32'h0080_0000, 32'hFFFE_0000, 32'h0080_0000,
                  32'd512, 32'd512, 0, 0, 250);
        // A tiny image, so counts pile up and the running peak keeps moving.
        run_phase(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000,
                  32'd4, 32'd3, 78, 0, 250);
        // No columns at all, and a height above the limit that saturates.
        run_phase(32'hFFFE_8000, 32'h0003_0000, 32'hFFFE_8000, 32'h0003_0000,
                  32'd0, 32'd1023, 0, 78, 120);
        run_phase(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                  32'd1, 32'd1, 14, 14, 100);
        // Width just above the limit; the height word has a bit above the ten that count.
        run_phase(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFF0, 32'hFFFF_FFFF,
                  32'd513, 32'h0000_0401, 0, 0, 100);

        // Random settings, cycling through the idling modes.
        for (int k = 0; k < 8; k++) begin
            run_phase(32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000,
                      $urandom_range(32'h0000_4000, 32'h0100_0000),
                      32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000,
                      $urandom_range(32'h0000_4000, 32'h0100_0000),
                      ($urandom_range(3) == 0) ? $urandom_range(1, 512) : $urandom_range(1, 12),
                      ($urandom_range(3) == 0) ? $urandom_range(1, 512) : $urandom_range(1, 12),
                      send_modes[k % 4], recv_modes[k % 4], 130);
        end

        // Everything answered; a few more cycles catch any stray result.
        drain_bins();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && bin_results_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run, clearing pass included.
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rdh_pkg.sv
hw/rtl/rdh_map.sv
hw/rtl/rdh_store.sv
hw/rtl/root_density_histogram.sv
hw/rtl/rdh_checker.sv
dv/tb_root_density_histogram.sv
